@@ hdl/rsf_pkg.sv @@
// ----------------------------------------------------------------------------
// rsf_pkg: shared types, constants and helpers
// Payload structures, register indexes, Q16.16 constants and the saturation
// helpers used by the rate-and-state friction step core.
// ----------------------------------------------------------------------------
package rsf_pkg;

    localparam int LOG_ITERATIONS = 16;
    localparam int ITER_W         = $clog2(LOG_ITERATIONS);

    localparam logic [31:0] ONE_Q     = 32'd65536;
    localparam logic [31:0] LN2_Q32   = 32'hB172_17F8;
    localparam logic [30:0] THETA_MAX = 31'h7FFF_FFFF;

    // Register indexes on the configuration port.
    localparam int          CFG_IDX_W          = 3;
    localparam logic [2:0]  REG_BASE_COEFF     = 3'd0;
    localparam logic [2:0]  REG_RATE_GAIN      = 3'd1;
    localparam logic [2:0]  REG_STATE_GAIN     = 3'd2;
    localparam logic [2:0]  REG_REF_VELOCITY   = 3'd3;
    localparam logic [2:0]  REG_CRIT_DISTANCE  = 3'd4;
    localparam logic [2:0]  REG_TIME_STEP      = 3'd5;

    // Reset values.
    localparam logic [30:0] RST_BASE_COEFF    = 31'd39322;
    localparam logic [31:0] RST_RATE_GAIN     = 32'd655;
    localparam logic [31:0] RST_STATE_GAIN    = 32'd983;
    localparam logic [30:0] RST_REF_VELOCITY  = 31'd65536;
    localparam logic [30:0] RST_CRIT_DISTANCE = 31'd65536;
    localparam logic [30:0] RST_TIME_STEP     = 31'd66;
    localparam logic [30:0] RST_THETA         = 31'd65536;

    typedef struct packed {
        logic               kind;
        logic signed [31:0] velocity;
        logic signed [31:0] previous_velocity;
        logic signed [31:0] tangential_force;
        logic signed [31:0] normal_force;
    } in_t;

    typedef struct packed {
        logic signed [31:0] friction_force;
        logic signed [31:0] new_tangential_force;
        logic               zero_velocity;
        logic               sticking;
        logic        [30:0] theta_out;
    } out_t;

    // Magnitude of a two's complement word; the most negative value maps to 2^31.
    function automatic logic [31:0] mag32(input logic [31:0] a);
        return a[31] ? (~a + 32'd1) : a;
    endfunction

    // Signed value from sign and magnitude, saturated to 32 bits.
    function automatic logic [31:0] sat_sm(input logic neg, input logic [47:0] m);
        logic [31:0] r;
        if (neg) begin
            r = (m > 48'h0000_8000_0000) ? 32'h8000_0000 : (~m[31:0] + 32'd1);
        end else begin
            r = (m > 48'h0000_7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
        end
        return r;
    endfunction

    // A 33-bit two's complement sum saturated to 32 bits.
    function automatic logic [31:0] sat33(input logic [32:0] s);
        logic [31:0] r;
        if (s[32] != s[31]) begin
            r = s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            r = s[31:0];
        end
        return r;
    endfunction

    // A 40-bit two's complement value saturated to 32 bits.
    function automatic logic [31:0] sat40(input logic [39:0] s);
        logic [31:0] r;
        if (s[39] && (s[38:31] != 8'hFF)) begin
            r = 32'h8000_0000;
        end else if (!s[39] && (s[38:31] != 8'h00)) begin
            r = 32'h7FFF_FFFF;
        end else begin
            r = s[31:0];
        end
        return r;
    endfunction

endpackage

@@ hdl/rsf_mul.sv @@
// ----------------------------------------------------------------------------
// rsf_mul: shared unsigned multiplier
// A 32 by 32 bit unsigned multiply with a registered 64-bit product; the
// sequencer presents operands in one cycle and reads the product in the next.
// ----------------------------------------------------------------------------
module rsf_mul (
    input  logic        aclk,
    input  logic [31:0] op_a,
    input  logic [31:0] op_b,
    output logic [63:0] product
);

    logic [63:0] product_reg;

    always_ff @(posedge aclk) begin
        product_reg <= 64'(op_a) * 64'(op_b);
    end

    assign product = product_reg;

endmodule

@@ hdl/rsf_div.sv @@
// ----------------------------------------------------------------------------
// rsf_div: iterative unsigned divider
// Restoring division of a 64-bit dividend by a non-zero 31-bit divisor, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module rsf_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [30:0] divisor,
    output logic        busy,
    output logic [63:0] quotient
);

    logic        busy_reg, busy_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [30:0] rem_reg, rem_next;
    logic [63:0] quo_reg, quo_next;
    logic [30:0] dvs_reg, dvs_next;
    logic [31:0] rem_sh;
    logic        ge;

    // The remainder stays below the divisor, so 31 bits hold it between steps.
    assign rem_sh = {rem_reg, quo_reg[63]};
    assign ge     = rem_sh >= {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = 6'd63;
            rem_next  = 31'd0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            rem_next = ge ? 31'(rem_sh - {1'b0, dvs_reg}) : rem_sh[30:0];
            quo_next = {quo_reg[62:0], ge};
            if (cnt_reg == 6'd0) begin
                busy_next = 1'b0;
            end else begin
                cnt_next = cnt_reg - 6'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

@@ hdl/rate_state_friction_step_core.sv @@
// ----------------------------------------------------------------------------
// rate_state_friction_step_core: rate-and-state friction step for one node
// Kind 0 items form mu from two natural logarithms and apply stick/slip
// rules; kind 1 items advance theta with the aging law. A small sequencer
// drives one shared multiplier and one bit-serial divider.
// ----------------------------------------------------------------------------
//  Channel   Direction  Signals                          Payload
//  s_        in         s_valid, s_ready, s_payload      rsf_pkg::in_t
//  m_        out        m_valid, m_ready, m_payload      rsf_pkg::out_t
//  cfg_      in         cfg_we, cfg_index, cfg_data      32-bit register data
//
//  A kind 0 item runs two divisions and two logarithms; a kind 1 item runs
//  one division, or none with a zero time step. Most of the time goes to
//  the 64-step divider and the squaring loop.
//  s_ready is high only while the sequencer is idle; a finished result waits
//  in the output register while the next item is taken in.
//  Reset is synchronous on aresetn and restores theta, the stick flag and the
//  registers.
// ----------------------------------------------------------------------------
module rate_state_friction_step_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [rsf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [31:0]                       cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  rsf_pkg::in_t                      s_payload,
    output logic                              m_valid,
    input  logic                              m_ready,
    output rsf_pkg::out_t                     m_payload
);

    localparam logic [4:0] ST_IDLE     = 5'd0;
    localparam logic [4:0] ST_START    = 5'd1;
    localparam logic [4:0] ST_DIV_WAIT = 5'd2;
    localparam logic [4:0] ST_NORM     = 5'd3;
    localparam logic [4:0] ST_SQ_MUL   = 5'd4;
    localparam logic [4:0] ST_SQ_TAKE  = 5'd5;
    localparam logic [4:0] ST_LN_MUL   = 5'd6;
    localparam logic [4:0] ST_LN_TAKE  = 5'd7;
    localparam logic [4:0] ST_G_MUL    = 5'd8;
    localparam logic [4:0] ST_G_TAKE   = 5'd9;
    localparam logic [4:0] ST_R2_MUL   = 5'd10;
    localparam logic [4:0] ST_R2_TAKE  = 5'd11;
    localparam logic [4:0] ST_NMU_MUL  = 5'd12;
    localparam logic [4:0] ST_FIN0     = 5'd13;
    localparam logic [4:0] ST_Q_MUL    = 5'd14;
    localparam logic [4:0] ST_Q_TAKE   = 5'd15;
    localparam logic [4:0] ST_A_MUL    = 5'd16;
    localparam logic [4:0] ST_A_TAKE   = 5'd17;
    localparam logic [4:0] ST_B_MUL    = 5'd18;
    localparam logic [4:0] ST_B_TAKE   = 5'd19;
    localparam logic [4:0] ST_OUT      = 5'd20;

    localparam logic [1:0] PH_R1 = 2'd0;
    localparam logic [1:0] PH_R2 = 2'd1;
    localparam logic [1:0] PH_Q  = 2'd2;

    localparam int LI = rsf_pkg::LOG_ITERATIONS;
    localparam int IW = rsf_pkg::ITER_W;

    // Configuration registers.
    logic [30:0] base_reg;
    logic [31:0] rate_gain_reg;
    logic [31:0] state_gain_reg;
    logic [30:0] vref_reg;
    logic [30:0] dc_reg;
    logic [30:0] dt_reg;

    logic [4:0]          state_reg, state_next;
    logic [1:0]          phase_reg, phase_next;
    rsf_pkg::in_t        item_reg, item_next;
    logic [30:0]         theta_reg, theta_next;
    logic                static_reg, static_next;
    logic [63:0]         x_reg, x_next;
    logic [5:0]          z_reg, z_next;
    logic [2:0]          nstep_reg, nstep_next;
    logic [30:0]         mant_reg, mant_next;
    logic [LI-1:0]       frac_reg, frac_next;
    logic [IW-1:0]       iter_reg, iter_next;
    logic [22:0]         ln_mag_reg, ln_mag_next;
    logic                ln_neg_reg, ln_neg_next;
    logic [39:0]         acc_reg, acc_next;
    logic [47:0]         age_m_reg, age_m_next;
    logic                age_neg_reg, age_neg_next;
    logic [63:0]         d_reg, d_next;
    logic [31:0]         fric_reg, fric_next;
    logic [31:0]         newt_reg, newt_next;
    logic                zv_reg, zv_next;
    logic                m_valid_reg, m_valid_next;
    rsf_pkg::out_t       m_payload_reg, m_payload_next;

    // Shared units.
    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;
    logic        div_start;
    logic [63:0] div_dividend;
    logic [30:0] div_divisor;
    logic        div_busy;
    logic [63:0] div_q;

    rsf_mul u_mul (
        .aclk    (aclk),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .product (prod)
    );

    rsf_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_q)
    );

    // Derived operands.
    logic [30:0] v0c, dcc;
    logic [31:0] v_mag, t_mag, n_mag, mu, mu_mag, gain, gain_mag;
    logic [6:0]  sh;
    logic [63:0] x_hi, x_sh;
    logic        hi_zero;
    logic [5:0]  z_sh;
    logic [5:0]  lead_pos;
    logic [6:0]  expo;
    logic [15:0] fq;
    logic [22:0] log2q, log2q_mag;
    logic [31:0] mm;
    logic [47:0] tsh;
    logic        nmu_neg, breakaway, reversal;
    logic [31:0] fric_t, fric_v, fric_neg_t, fric_sel;
    logic [63:0] d_sum;
    logic [64:0] theta_sum;

    assign v0c = (vref_reg == 31'd0) ? 31'd1 : vref_reg;
    assign dcc = (dc_reg == 31'd0) ? 31'd1 : dc_reg;

    assign v_mag    = rsf_pkg::mag32(item_reg.velocity);
    assign t_mag    = rsf_pkg::mag32(item_reg.tangential_force);
    assign n_mag    = rsf_pkg::mag32(item_reg.normal_force);
    assign mu       = rsf_pkg::sat40(acc_reg);
    assign mu_mag   = rsf_pkg::mag32(mu);
    assign gain     = (phase_reg == PH_R1) ? rate_gain_reg : state_gain_reg;
    assign gain_mag = rsf_pkg::mag32(gain);

    // Leading-one search: six halving steps of 32, 16, 8, 4, 2 and 1 bits.
    assign sh      = 7'd32 >> nstep_reg;
    assign x_hi    = x_reg >> (7'd64 - sh);
    assign hi_zero = (x_hi == 64'd0);
    assign x_sh    = hi_zero ? (x_reg << sh) : x_reg;
    assign z_sh    = hi_zero ? (z_reg + sh[5:0]) : z_reg;

    assign lead_pos  = 6'd63 - z_reg;
    assign expo      = 7'(lead_pos) - 7'd16;
    assign fq        = 16'({frac_reg, 16'd0} >> LI);
    assign log2q     = {expo, fq};
    assign log2q_mag = log2q[22] ? (~log2q + 23'd1) : log2q;

    assign mm = prod[61:30];

    // Stick/slip decision inputs.
    assign tsh        = {t_mag, 16'd0};
    assign nmu_neg    = item_reg.normal_force[31] ^ mu[31];
    assign breakaway  = nmu_neg ? ((prod != 64'd0) || (t_mag != 32'd0))
                                : ({16'd0, tsh} > prod);
    assign reversal   = (item_reg.previous_velocity != 32'sd0) &&
                        ((item_reg.velocity == 32'sd0) ||
                         (item_reg.velocity[31] != item_reg.previous_velocity[31]));
    assign fric_t     = (t_mag == 32'd0) ? 32'd0 :
                        rsf_pkg::sat_sm(nmu_neg ^ ~item_reg.tangential_force[31],
                                        prod[63:16]);
    assign fric_v     = (v_mag == 32'd0) ? 32'd0 :
                        rsf_pkg::sat_sm(nmu_neg ^ ~item_reg.velocity[31], prod[63:16]);
    assign fric_neg_t = rsf_pkg::sat_sm(~item_reg.tangential_force[31], {16'd0, t_mag});

    assign d_sum     = d_reg + 64'(prod[63:16]);
    assign theta_sum = 65'(d_sum) + 65'(theta_reg);

    always_comb begin
        if (static_reg) begin
            fric_sel = breakaway ? fric_t : fric_neg_t;
        end else if (reversal) begin
            fric_sel = fric_neg_t;
        end else begin
            fric_sel = fric_v;
        end
    end

    always_comb begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        item_next      = item_reg;
        theta_next     = theta_reg;
        static_next    = static_reg;
        x_next         = x_reg;
        z_next         = z_reg;
        nstep_next     = nstep_reg;
        mant_next      = mant_reg;
        frac_next      = frac_reg;
        iter_next      = iter_reg;
        ln_mag_next    = ln_mag_reg;
        ln_neg_next    = ln_neg_reg;
        acc_next       = acc_reg;
        age_m_next     = age_m_reg;
        age_neg_next   = age_neg_reg;
        d_next         = d_reg;
        fric_next      = fric_reg;
        newt_next      = newt_reg;
        zv_next        = zv_reg;
        m_valid_next   = m_valid_reg;
        m_payload_next = m_payload_reg;
        mul_a          = 32'd0;
        mul_b          = 32'd0;
        div_start      = 1'b0;
        div_dividend   = 64'(prod);
        div_divisor    = dcc;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    item_next  = s_payload;
                    state_next = ST_START;
                end
            end
            ST_START: begin
                fric_next = 32'd0;
                newt_next = item_reg.tangential_force;
                zv_next   = 1'b0;
                acc_next  = 40'(base_reg);
                if (!item_reg.kind) begin
                    div_start    = 1'b1;
                    div_dividend = 64'({v_mag, 16'd0});
                    div_divisor  = v0c;
                    phase_next   = PH_R1;
                    state_next   = ST_DIV_WAIT;
                end else if (dt_reg == 31'd0) begin
                    state_next = ST_OUT;
                end else begin
                    phase_next = PH_Q;
                    state_next = ST_Q_MUL;
                end
            end
            ST_DIV_WAIT: begin
                if (!div_busy) begin
                    if (phase_reg == PH_Q) begin
                        if (div_q <= 64'(rsf_pkg::ONE_Q)) begin
                            age_m_next   = 48'(64'(rsf_pkg::ONE_Q) - div_q);
                            age_neg_next = 1'b0;
                            state_next   = ST_A_MUL;
                        end else if (div_q >= 64'h0001_0000_0001_0000) begin
                            // Decrement far beyond any theta: theta collapses to zero.
                            theta_next = 31'd0;
                            state_next = ST_OUT;
                        end else begin
                            age_m_next   = 48'(div_q - 64'(rsf_pkg::ONE_Q));
                            age_neg_next = 1'b1;
                            state_next   = ST_A_MUL;
                        end
                    end else begin
                        x_next     = (div_q == 64'd0) ? 64'd1 : div_q;
                        z_next     = 6'd0;
                        nstep_next = 3'd0;
                        state_next = ST_NORM;
                    end
                end
            end
            ST_NORM: begin
                x_next     = x_sh;
                z_next     = z_sh;
                nstep_next = nstep_reg + 3'd1;
                if (nstep_reg == 3'd5) begin
                    mant_next  = x_sh[63:33];
                    frac_next  = '0;
                    iter_next  = '0;
                    state_next = ST_SQ_MUL;
                end
            end
            ST_SQ_MUL: begin
                mul_a      = 32'(mant_reg);
                mul_b      = 32'(mant_reg);
                state_next = ST_SQ_TAKE;
            end
            ST_SQ_TAKE: begin
                if (mm[31]) begin
                    mant_next = mm[31:1];
                    frac_next = {frac_reg[LI-2:0], 1'b1};
                end else begin
                    mant_next = mm[30:0];
                    frac_next = {frac_reg[LI-2:0], 1'b0};
                end
                iter_next = iter_reg + IW'(1);
                if (iter_reg == IW'(LI - 1)) begin
                    state_next = ST_LN_MUL;
                end else begin
                    state_next = ST_SQ_MUL;
                end
            end
            ST_LN_MUL: begin
                mul_a      = 32'(log2q_mag);
                mul_b      = rsf_pkg::LN2_Q32;
                state_next = ST_LN_TAKE;
            end
            ST_LN_TAKE: begin
                ln_mag_next = prod[54:32];
                ln_neg_next = log2q[22];
                state_next  = ST_G_MUL;
            end
            ST_G_MUL: begin
                mul_a      = gain_mag;
                mul_b      = 32'(ln_mag_reg);
                state_next = ST_G_TAKE;
            end
            ST_G_TAKE: begin
                if (gain[31] ^ ln_neg_reg) begin
                    acc_next = acc_reg - 40'(prod[53:16]);
                end else begin
                    acc_next = acc_reg + 40'(prod[53:16]);
                end
                state_next = (phase_reg == PH_R1) ? ST_R2_MUL : ST_NMU_MUL;
            end
            ST_R2_MUL: begin
                mul_a      = 32'(v0c);
                mul_b      = 32'(theta_reg);
                state_next = ST_R2_TAKE;
            end
            ST_R2_TAKE: begin
                div_start  = 1'b1;
                phase_next = PH_R2;
                state_next = ST_DIV_WAIT;
            end
            ST_NMU_MUL: begin
                mul_a      = n_mag;
                mul_b      = mu_mag;
                state_next = ST_FIN0;
            end
            ST_FIN0: begin
                fric_next = fric_sel;
                newt_next = rsf_pkg::sat33({item_reg.tangential_force[31],
                                            item_reg.tangential_force} +
                                           {fric_sel[31], fric_sel});
                if (static_reg) begin
                    if (breakaway) begin
                        static_next = 1'b0;
                    end
                end else if (reversal) begin
                    static_next = 1'b1;
                    zv_next     = 1'b1;
                end
                state_next = ST_OUT;
            end
            ST_Q_MUL: begin
                mul_a      = v_mag;
                mul_b      = 32'(theta_reg);
                state_next = ST_Q_TAKE;
            end
            ST_Q_TAKE: begin
                div_start  = 1'b1;
                state_next = ST_DIV_WAIT;
            end
            ST_A_MUL: begin
                mul_a      = age_m_reg[47:16];
                mul_b      = 32'(dt_reg);
                state_next = ST_A_TAKE;
            end
            ST_A_TAKE: begin
                d_next     = prod;
                state_next = ST_B_MUL;
            end
            ST_B_MUL: begin
                mul_a      = 32'(age_m_reg[15:0]);
                mul_b      = 32'(dt_reg);
                state_next = ST_B_TAKE;
            end
            ST_B_TAKE: begin
                if (age_neg_reg) begin
                    theta_next = (d_sum > 64'(theta_reg)) ? 31'd0 : (theta_reg - d_sum[30:0]);
                end else begin
                    theta_next = (theta_sum > 65'(rsf_pkg::THETA_MAX)) ?
                                 rsf_pkg::THETA_MAX : theta_sum[30:0];
                end
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next                        = 1'b1;
                    m_payload_next.friction_force       = fric_reg;
                    m_payload_next.new_tangential_force = newt_reg;
                    m_payload_next.zero_velocity        = zv_reg;
                    m_payload_next.sticking             = static_reg;
                    m_payload_next.theta_out            = theta_reg;
                    state_next                          = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            phase_reg   <= PH_R1;
            theta_reg   <= rsf_pkg::RST_THETA;
            static_reg  <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            theta_reg   <= theta_next;
            static_reg  <= static_next;
            m_valid_reg <= m_valid_next;
        end
        item_reg      <= item_next;
        x_reg         <= x_next;
        z_reg         <= z_next;
        nstep_reg     <= nstep_next;
        mant_reg      <= mant_next;
        frac_reg      <= frac_next;
        iter_reg      <= iter_next;
        ln_mag_reg    <= ln_mag_next;
        ln_neg_reg    <= ln_neg_next;
        acc_reg       <= acc_next;
        age_m_reg     <= age_m_next;
        age_neg_reg   <= age_neg_next;
        d_reg         <= d_next;
        fric_reg      <= fric_next;
        newt_reg      <= newt_next;
        zv_reg        <= zv_next;
        m_payload_reg <= m_payload_next;
    end

    // Register writes; the narrower registers keep the low 31 bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg       <= rsf_pkg::RST_BASE_COEFF;
            rate_gain_reg  <= rsf_pkg::RST_RATE_GAIN;
            state_gain_reg <= rsf_pkg::RST_STATE_GAIN;
            vref_reg       <= rsf_pkg::RST_REF_VELOCITY;
            dc_reg         <= rsf_pkg::RST_CRIT_DISTANCE;
            dt_reg         <= rsf_pkg::RST_TIME_STEP;
        end else if (cfg_we) begin
            case (cfg_index)
                rsf_pkg::REG_BASE_COEFF:    base_reg       <= cfg_data[30:0];
                rsf_pkg::REG_RATE_GAIN:     rate_gain_reg  <= cfg_data;
                rsf_pkg::REG_STATE_GAIN:    state_gain_reg <= cfg_data;
                rsf_pkg::REG_REF_VELOCITY:  vref_reg       <= cfg_data[30:0];
                rsf_pkg::REG_CRIT_DISTANCE: dc_reg         <= cfg_data[30:0];
                rsf_pkg::REG_TIME_STEP:     dt_reg         <= cfg_data[30:0];
                default: begin
                end
            endcase
        end
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

`ifndef SYNTHESIS
    // Once an item is taken, no further transfer is accepted until it is done.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while an item is in progress");

    // The divider must be free whenever the sequencer is idle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !div_busy)
        else $error("divider busy while the sequencer is idle");

    // A result that zeroes the velocity must also report the node as stuck.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_payload.zero_velocity) |-> m_payload.sticking)
        else $error("zero velocity without sticking");

    // Sticking cancels the force, so the new tangential force is zero or one below.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_payload.zero_velocity) |->
            ((m_payload.new_tangential_force == 32'sd0) ||
             (m_payload.new_tangential_force == -32'sd1)))
        else $error("stuck node left a residual tangential force");
`endif

endmodule

@@ dv/rate_state_friction_step_checker.sv @@
// ----------------------------------------------------------------------------
// rate_state_friction_step_checker: result predictor and scoreboard
// Watches the configuration port and both channels of the friction step core.
// It keeps its own copy of the registers, theta and the stick flag, works out
// the result of every input transfer and compares each output transfer, field
// by field, with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module rate_state_friction_step_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [rsf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  rsf_pkg::in_t                  s_payload,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  rsf_pkg::out_t                 m_payload,
    output int                            mismatch_count,
    output int                            results_waiting
);

    logic [30:0]        mu0_reg;
    logic signed [31:0] a_gain_reg;
    logic signed [31:0] b_gain_reg;
    logic [30:0]        v0_reg;
    logic [30:0]        dc_reg;
    logic [30:0]        dt_reg;
    longint             theta_q;
    bit                 stuck;

    rsf_pkg::out_t predicted_results[$];
    int            printed;

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (printed < 40) begin
            $display("MISMATCH at %0t: %s", $realtime, what);
            printed++;
        end
    endtask

    function automatic longint unsigned magnitude(input longint a);
        return (a < 0) ? longint'(64'd0) - a : a;
    endfunction

    function automatic longint sign_of(input longint a);
        return (a > 0) ? 64'sd1 : ((a < 0) ? -64'sd1 : 64'sd0);
    endfunction

    // Product shifted right, truncated toward zero.
    function automatic longint scaled_product(input longint a, input longint b, input int s);
        longint unsigned p;
        p = (magnitude(a) * magnitude(b)) >> s;
        return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
    endfunction

    function automatic longint clip32(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // Natural log of a Q16.16 value: integer part from the leading one,
    // fraction bits of log2 by repeated squaring, then scaled by ln 2.
    function automatic longint natural_log(input longint unsigned x);
        int              p;
        longint unsigned m;
        longint unsigned frac;
        longint unsigned fq;
        longint          log2q;
        if (x == 0)
            x = 1;
        p = 63;
        while (!x[p])
            p--;
        m    = (p >= 30) ? (x >> (p - 30)) : (x << (30 - p));
        frac = 0;
        for (int i = 0; i < rsf_pkg::LOG_ITERATIONS; i++) begin
            m    = (m * m) >> 30;
            frac = frac << 1;
            if (m >= 64'h8000_0000) begin
                m    = m >> 1;
                frac = frac | 64'd1;
            end
        end
        fq = (rsf_pkg::LOG_ITERATIONS >= 16) ? (frac >> (rsf_pkg::LOG_ITERATIONS - 16))
                                             : (frac << (16 - rsf_pkg::LOG_ITERATIONS));
        log2q = longint'(p - 16) * 65536 + longint'(fq);
        return scaled_product(log2q, longint'({32'd0, rsf_pkg::LN2_Q32}), 32);
    endfunction

    function automatic rsf_pkg::out_t friction_step(input rsf_pkg::in_t it);
        rsf_pkg::out_t   r;
        longint          v, vp, t, n, fric, newt, mu, nmu, term, nt;
        longint unsigned v0, dc, r1, r2, q, m, d, dt;
        bit              zero_v;
        v      = it.velocity;
        vp     = it.previous_velocity;
        t      = it.tangential_force;
        n      = it.normal_force;
        v0     = (v0_reg == 0) ? 64'd1 : {33'd0, v0_reg};
        dc     = (dc_reg == 0) ? 64'd1 : {33'd0, dc_reg};
        fric   = 0;
        newt   = t;
        zero_v = 0;
        if (it.kind == 1'b0) begin
            r1 = (magnitude(v) << 16) / v0;
            r2 = (v0 * longint'(theta_q)) / dc;
            mu = longint'({33'd0, mu0_reg})
               + scaled_product(longint'(a_gain_reg), natural_log(r1), 16)
               + scaled_product(longint'(b_gain_reg), natural_log(r2), 16);
            mu  = clip32(mu);
            nmu = n * mu;
            if (stuck) begin
                if (longint'(magnitude(t) << 16) > nmu) begin
                    stuck = 0;
                    fric  = -sign_of(t) * scaled_product(n, mu, 16);
                end else begin
                    fric = -t;
                end
            end else if (sign_of(v) != sign_of(vp) && vp != 0) begin
                // Velocity reversed: the node sticks again.
                stuck  = 1;
                fric   = -t;
                zero_v = 1;
            end else begin
                fric = -sign_of(v) * scaled_product(n, mu, 16);
            end
            fric = clip32(fric);
            newt = clip32(t + fric);
        end else if (dt_reg != 0) begin
            q    = (magnitude(v) * longint'(theta_q)) / dc;
            term = 64'sd65536 - longint'(q);
            dt   = {33'd0, dt_reg};
            if (term < 0 && magnitude(term) >= (64'd1 << 48)) begin
                theta_q = 0;
            end else begin
                m  = magnitude(term);
                d  = (m >> 16) * dt + (((m & 64'hFFFF) * dt) >> 16);
                nt = (term < 0) ? theta_q - longint'(d) : theta_q + longint'(d);
                if (nt < 0)
                    nt = 0;
                if (nt > 64'sd2147483647)
                    nt = 64'sd2147483647;
                theta_q = nt;
            end
        end
        r.friction_force       = fric[31:0];
        r.new_tangential_force = newt[31:0];
        r.zero_velocity        = zero_v;
        r.sticking             = stuck;
        r.theta_out            = theta_q[30:0];
        return r;
    endfunction

    always @(posedge aclk) begin
        rsf_pkg::out_t want;
        if (!aresetn) begin
            mu0_reg    <= rsf_pkg::RST_BASE_COEFF;
            a_gain_reg <= rsf_pkg::RST_RATE_GAIN;
            b_gain_reg <= rsf_pkg::RST_STATE_GAIN;
            v0_reg     <= rsf_pkg::RST_REF_VELOCITY;
            dc_reg     <= rsf_pkg::RST_CRIT_DISTANCE;
            dt_reg     <= rsf_pkg::RST_TIME_STEP;
            theta_q    = rsf_pkg::RST_THETA;
            stuck      = 1;
            predicted_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (predicted_results.size() == 0) begin
                    report_mismatch("result transfer with no prediction waiting");
                end else begin
                    want = predicted_results.pop_front();
                    if (m_payload.friction_force !== want.friction_force)
                        report_mismatch($sformatf("friction_force got %h want %h",
                            m_payload.friction_force, want.friction_force));
                    if (m_payload.new_tangential_force !== want.new_tangential_force)
                        report_mismatch($sformatf("new_tangential_force got %h want %h",
                            m_payload.new_tangential_force, want.new_tangential_force));
                    if (m_payload.zero_velocity !== want.zero_velocity)
                        report_mismatch($sformatf("zero_velocity got %b want %b",
                            m_payload.zero_velocity, want.zero_velocity));
                    if (m_payload.sticking !== want.sticking)
                        report_mismatch($sformatf("sticking got %b want %b",
                            m_payload.sticking, want.sticking));
                    if (m_payload.theta_out !== want.theta_out)
                        report_mismatch($sformatf("theta_out got %h want %h",
                            m_payload.theta_out, want.theta_out));
                end
            end
            if (s_valid && s_ready)
                predicted_results.push_back(friction_step(s_payload));
            if (cfg_we) begin
                case (cfg_index)
                    rsf_pkg::REG_BASE_COEFF:    mu0_reg    <= cfg_data[30:0];
                    rsf_pkg::REG_RATE_GAIN:     a_gain_reg <= cfg_data;
                    rsf_pkg::REG_STATE_GAIN:    b_gain_reg <= cfg_data;
                    rsf_pkg::REG_REF_VELOCITY:  v0_reg     <= cfg_data[30:0];
                    rsf_pkg::REG_CRIT_DISTANCE: dc_reg     <= cfg_data[30:0];
                    rsf_pkg::REG_TIME_STEP:     dt_reg     <= cfg_data[30:0];
                    default: ;
                endcase
            end
        end
        results_waiting <= predicted_results.size();
    end

endmodule

@@ dv/rate_state_friction_step_core_tb.sv @@
// ----------------------------------------------------------------------------
// rate_state_friction_step_core_tb: stimulus and verdict for the friction core
// Drives directed and random friction and theta items through several register
// settings, with random idling on both channels and one long output hold-off.
// Checking is done by the checker instantiated beside the core.
// ----------------------------------------------------------------------------
module rate_state_friction_step_core_tb;

    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int PHASE_ITEMS  = 270;
    localparam int DRAIN_CYCLES = 300;

    logic                          aclk;
    logic                          aresetn;
    logic                          cfg_we;
    logic [rsf_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [31:0]                   cfg_data;
    logic                          s_valid;
    logic                          s_ready;
    rsf_pkg::in_t                  s_payload;
    logic                          m_valid;
    logic                          m_ready;
    rsf_pkg::out_t                 m_payload;

    int mismatch_count;
    int results_waiting;
    int cycle_count;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_left;
    bit hold_request;
    bit hold_done;
    int items_sent;
    int settings_used;
    int stream_velocity;

    rate_state_friction_step_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    rate_state_friction_step_checker checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_payload       (s_payload),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_payload       (m_payload),
        .mismatch_count  (mismatch_count),
        .results_waiting (results_waiting)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Receiver: random back-pressure, or a long hold-off when one is asked for.
    always @(posedge aclk) begin
        if (hold_request && !hold_done) begin
            hold_done = 1;
            hold_left = 4000;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic write_registers(input logic [31:0] values [6]);
        for (int i = 0; i < 6; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= rsf_pkg::CFG_IDX_W'(i);
            cfg_data  <= values[i];
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Offer one item and hold it until the transfer; an idle gap may follow.
    task automatic send_item(input rsf_pkg::in_t it);
        s_payload <= it;
        s_valid   <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (results_waiting != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(5))
            0, 1: return $urandom();
            2:    return $urandom_range(1 << 20);
            3:    return -$urandom_range(1 << 20);
            4: begin
                case ($urandom_range(4))
                    0: return 32'h0000_0000;
                    1: return 32'h0000_0001;
                    2: return 32'hFFFF_FFFF;
                    3: return 32'h8000_0000;
                    default: return 32'h7FFF_FFFF;
                endcase
            end
            default: return $urandom_range(1 << 24, 1 << 16);
        endcase
    endfunction

    // Mostly a plausible motion history: the previous velocity follows on,
    // reversals happen now and then, and theta steps are interleaved.
    function automatic rsf_pkg::in_t pick_item();
        rsf_pkg::in_t it;
        int           dv;
        if ($urandom_range(99) < 75) begin
            it.kind              = ($urandom_range(99) < 30);
            it.previous_velocity = stream_velocity;
            dv = $signed($urandom_range(1 << 17)) - (1 << 16);
            if ($urandom_range(9) == 0)
                stream_velocity = -stream_velocity + dv;
            else
                stream_velocity = stream_velocity + dv;
            it.velocity         = stream_velocity;
            it.tangential_force = $signed($urandom_range(1 << 19)) - (1 << 18);
            it.normal_force     = $urandom_range(1 << 19);
        end else begin
            it.kind              = $urandom_range(1);
            it.velocity          = pick_word();
            it.previous_velocity = pick_word();
            it.tangential_force  = pick_word();
            it.normal_force      = pick_word();
            stream_velocity      = it.velocity;
        end
        return it;
    endfunction

    function automatic rsf_pkg::in_t make_item(input logic k, input logic [31:0] v,
                                               input logic [31:0] vp,
                                               input logic [31:0] t, input logic [31:0] n);
        rsf_pkg::in_t it;
        it.kind              = k;
        it.velocity          = v;
        it.previous_velocity = vp;
        it.tangential_force  = t;
        it.normal_force      = n;
        return it;
    endfunction

    initial begin
        logic [31:0] regs [6];
        aresetn         <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_index       <= '0;
        cfg_data        <= '0;
        s_valid         <= 1'b0;
        s_payload       <= '0;
        hold_request    = 0;
        items_sent      = 0;
        settings_used   = 0;
        stream_velocity = 65536;
        send_idle_pct   = 0;
        recv_idle_pct   = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed items at the reset settings: zero and extreme velocities
        // (log argument clamped), a breakaway, slip, a reversal to stick,
        // theta growth and decay, and saturating forces.
        send_item(make_item(1'b0, 32'h0, 32'h0, 32'h0, 32'h0));
        send_item(make_item(1'b0, 32'h0, 32'h0, 32'h0001_0000, 32'h0010_0000));
        send_item(make_item(1'b0, 32'h0001_0000, 32'h0, 32'h7FFF_FFFF, 32'h0001_0000));
        send_item(make_item(1'b0, 32'h0002_0000, 32'h0001_0000, 32'h0, 32'h7FFF_FFFF));
        send_item(make_item(1'b0, 32'h7FFF_FFFF, 32'h0002_0000, 32'h0, 32'h8000_0000));
        send_item(make_item(1'b0, 32'hFFFF_0000, 32'h0001_0000, 32'h0003_0000, 32'h0001_0000));
        send_item(make_item(1'b0, 32'h0, 32'h0, 32'h8000_0000, 32'h0001_0000));
        send_item(make_item(1'b0, 32'h8000_0000, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF));
        send_item(make_item(1'b0, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_item(make_item(1'b0, 32'h0001_0000, 32'hFFFF_0000, 32'h0001_0000, 32'h0));
        send_item(make_item(1'b1, 32'h0, 32'h0, 32'h1234_5678, 32'h0));
        send_item(make_item(1'b1, 32'h0000_0100, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0));
        send_item(make_item(1'b1, 32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000));
        send_item(make_item(1'b1, 32'h8000_0000, 32'h0, 32'h0, 32'h0));
        send_item(make_item(1'b0, 32'h0000_0001, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_item(make_item(1'b0, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0, 32'h0001_0000));
        send_item(make_item(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_item(make_item(1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000));
        wait_idle();

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: regs = '{32'd39322, 32'd655, 32'd983, 32'd65536, 32'd65536, 32'd66};
                1: regs = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
                2: regs = '{32'h0, 32'h8000_0000, 32'h8000_0000, 32'd1, 32'd1, 32'd1};
                3: regs = '{32'd52429, -32'd655, 32'h0, 32'h0, 32'h0, 32'h0};
                4: regs = '{$urandom(), $urandom(), $urandom(),
                            $urandom(), $urandom(), $urandom()};
                default: regs = '{32'd39322, 32'd655, 32'd983, 32'd256, 32'd16384, 32'd4096};
            endcase
            write_registers(regs);
            send_idle_pct = (phase < 2) ? 24 : ((phase < 4) ? 73 : 0);
            recv_idle_pct = (phase < 2) ? 73 : ((phase < 4) ? 24 : 0);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                // Hold the output off for a long stretch while items keep coming.
                if (phase == 5 && i == 20)
                    hold_request = 1;
                send_item(pick_item());
            end
            wait_idle();
        end

        $display("run covered %0d items under %0d register settings,", items_sent,
                 settings_used);
        $display("with idling on either side, none at all, and one long output hold-off");
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

@@ rate_state_friction_step_core.f @@
hdl/rsf_pkg.sv
hdl/rsf_mul.sv
hdl/rsf_div.sv
hdl/rate_state_friction_step_core.sv
dv/rate_state_friction_step_checker.sv
dv/rate_state_friction_step_core_tb.sv
